// ----- rtl/arsp_pkg.sv -----
// Package for the arrival record stream parser: sizes, byte role codes and transaction types.
package arsp_pkg;

    localparam int MAX_ENTRIES  = 8;
    localparam int ROUTE_CAP    = 8;
    localparam int HEADSIGN_CAP = 32;

    // entry counters must hold MAX_ENTRIES itself
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [7:0] MAX_ENTRIES_B = 8'(MAX_ENTRIES);
    localparam logic [7:0] ROUTE_KEEP    = 8'(ROUTE_CAP - 1);
    localparam logic [7:0] HEAD_KEEP     = 8'(HEADSIGN_CAP - 1);

    // byte role codes as shown on the result channel
    localparam logic [3:0] KIND_COUNT     = 4'd0;
    localparam logic [3:0] KIND_RED       = 4'd1;
    localparam logic [3:0] KIND_GREEN     = 4'd2;
    localparam logic [3:0] KIND_BLUE      = 4'd3;
    localparam logic [3:0] KIND_ROUTE_LEN = 4'd4;
    localparam logic [3:0] KIND_ROUTE_CHR = 4'd5;
    localparam logic [3:0] KIND_HEAD_LEN  = 4'd6;
    localparam logic [3:0] KIND_HEAD_CHR  = 4'd7;
    localparam logic [3:0] KIND_MIN_HI    = 4'd8;
    localparam logic [3:0] KIND_MIN_LO    = 4'd9;
    localparam logic [3:0] KIND_STATUS    = 4'd10;
    localparam logic [3:0] KIND_IGNORED   = 4'd11;
    localparam logic [3:0] KIND_EMPTY     = 4'd12;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_payload;
    } arsp_in_t;

    typedef struct packed {
        logic [3:0]        byte_kind;
        logic [7:0]        data_value;
        logic [2:0]        entry_index;
        logic [7:0]        char_pos;
        logic              kept;
        logic              entry_done;
        logic [15:0]       minutes;
        logic signed [7:0] status_code;
        logic              payload_done;
        logic [3:0]        entries_parsed;
        logic              truncated;
    } arsp_out_t;

endpackage

// ----- rtl/arrival_record_stream_parser.sv -----
// Arrival record stream parser: tags each payload byte with its role, one byte per clock while results are taken.
//
//  Channel  Dir  Handshake          Transaction
//  s_       in   s_valid / s_ready  arsp_in_t  (one payload byte)
//  m_       out  m_valid / m_ready  arsp_out_t (role and entry results of that byte)
//
// One byte per clock sustained while m_ready holds; each result is registered in the output register.
// The parse state is a one-hot phase register plus small counters updated in one step.
// An output register and a skid register decouple the sides: s_ready is registered and
// drops only when both hold a result.
// aresetn (synchronous) returns the parser to expecting a count byte and empties both.
module arrival_record_stream_parser
    import arsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  arsp_in_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output arsp_out_t m_item
);

    typedef enum logic [11:0] {
        PH_COUNT  = 12'b0000_0000_0001,
        PH_RED    = 12'b0000_0000_0010,
        PH_GREEN  = 12'b0000_0000_0100,
        PH_BLUE   = 12'b0000_0000_1000,
        PH_RLEN   = 12'b0000_0001_0000,
        PH_RCHAR  = 12'b0000_0010_0000,
        PH_HLEN   = 12'b0000_0100_0000,
        PH_HCHAR  = 12'b0000_1000_0000,
        PH_MHI    = 12'b0001_0000_0000,
        PH_MLO    = 12'b0010_0000_0000,
        PH_STATUS = 12'b0100_0000_0000,
        PH_IGNORE = 12'b1000_0000_0000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] target_reg, target_next;
    logic [CNT_W-1:0] done_reg, done_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       pos_reg, pos_next;
    logic [7:0]       min_hi_reg, min_hi_next;
    logic [7:0]       min_lo_reg, min_lo_next;

    arsp_out_t        out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    arsp_out_t        res;
    logic             s_fire;
    logic             m_fire;
    logic             is_last;
    logic [7:0]       left_dec;
    logic [CNT_W-1:0] done_inc;
    logic [7:0]       clamped;

    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;
    assign m_fire  = out_valid_reg && m_ready;

    assign left_dec = left_reg - 8'd1;
    assign done_inc = done_reg + CNT_W'(1);
    assign clamped  = (s_item.data_byte > MAX_ENTRIES_B) ? MAX_ENTRIES_B : s_item.data_byte;
    assign is_last  = s_item.last_byte || s_item.empty_payload;

    always_comb begin
        phase_next  = phase_reg;
        target_next = target_reg;
        done_next   = done_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        min_hi_next = min_hi_reg;
        min_lo_next = min_lo_reg;

        res                = '0;
        res.data_value     = s_item.data_byte;
        res.payload_done   = is_last;

        if (s_item.empty_payload) begin
            res.byte_kind  = KIND_EMPTY;
            res.data_value = '0;
        end else begin
            if (phase_reg != PH_COUNT && phase_reg != PH_IGNORE) begin
                res.entry_index = 3'(done_reg);
            end
            unique case (phase_reg)
                PH_COUNT: begin
                    res.byte_kind = KIND_COUNT;
                    target_next   = CNT_W'(clamped);
                    done_next     = '0;
                    phase_next    = (clamped == 8'd0) ? PH_IGNORE : PH_RED;
                end
                PH_RED: begin
                    res.byte_kind = KIND_RED;
                    phase_next    = PH_GREEN;
                end
                PH_GREEN: begin
                    res.byte_kind = KIND_GREEN;
                    phase_next    = PH_BLUE;
                end
                PH_BLUE: begin
                    res.byte_kind = KIND_BLUE;
                    phase_next    = PH_RLEN;
                end
                PH_RLEN: begin
                    res.byte_kind = KIND_ROUTE_LEN;
                    left_next     = s_item.data_byte;
                    pos_next      = '0;
                    phase_next    = (s_item.data_byte == 8'd0) ? PH_HLEN : PH_RCHAR;
                end
                PH_RCHAR: begin
                    res.byte_kind = KIND_ROUTE_CHR;
                    res.char_pos  = pos_reg;
                    res.kept      = pos_reg < ROUTE_KEEP;
                    pos_next      = pos_reg + 8'd1;
                    left_next     = left_dec;
                    if (left_dec == 8'd0) begin
                        phase_next = PH_HLEN;
                    end
                end
                PH_HLEN: begin
                    res.byte_kind = KIND_HEAD_LEN;
                    left_next     = s_item.data_byte;
                    pos_next      = '0;
                    phase_next    = (s_item.data_byte == 8'd0) ? PH_MHI : PH_HCHAR;
                end
                PH_HCHAR: begin
                    res.byte_kind = KIND_HEAD_CHR;
                    res.char_pos  = pos_reg;
                    res.kept      = pos_reg < HEAD_KEEP;
                    pos_next      = pos_reg + 8'd1;
                    left_next     = left_dec;
                    if (left_dec == 8'd0) begin
                        phase_next = PH_MHI;
                    end
                end
                PH_MHI: begin
                    res.byte_kind = KIND_MIN_HI;
                    min_hi_next   = s_item.data_byte;
                    phase_next    = PH_MLO;
                end
                PH_MLO: begin
                    res.byte_kind = KIND_MIN_LO;
                    min_lo_next   = s_item.data_byte;
                    phase_next    = PH_STATUS;
                end
                PH_STATUS: begin
                    res.byte_kind   = KIND_STATUS;
                    res.entry_done  = 1'b1;
                    res.minutes     = {min_hi_reg, min_lo_reg};
                    res.status_code = s_item.data_byte;
                    done_next       = done_inc;
                    phase_next      = (done_inc >= target_reg) ? PH_IGNORE : PH_RED;
                end
                PH_IGNORE: begin
                    res.byte_kind = KIND_IGNORED;
                end
                default: begin
                    res.byte_kind = KIND_IGNORED;
                    phase_next    = PH_IGNORE;
                end
            endcase
        end

        res.entries_parsed = 4'(done_next);

        if (is_last) begin
            res.truncated = done_next < target_next;
            phase_next    = PH_COUNT;
            target_next   = '0;
            done_next     = '0;
            left_next     = '0;
            pos_next      = '0;
            min_hi_next   = '0;
            min_lo_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_COUNT;
            target_reg <= '0;
            done_reg   <= '0;
            left_reg   <= '0;
            pos_reg    <= '0;
            min_hi_reg <= '0;
            min_lo_reg <= '0;
        end else if (s_fire) begin
            phase_reg  <= phase_next;
            target_reg <= target_next;
            done_reg   <= done_next;
            left_reg   <= left_next;
            pos_reg    <= pos_next;
            min_hi_reg <= min_hi_next;
            min_lo_reg <= min_lo_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_fire) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (!out_valid_reg || m_ready) begin
                out_valid_reg <= s_fire;
            end else if (s_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || m_ready) begin
            if (s_fire) begin
                out_reg <= res;
            end
        end else if (s_fire) begin
            skid_reg <= res;
        end
    end

endmodule

// ----- rtl/arsp_checker.sv -----
// Port-level checker for the arrival record stream parser, bound to the top level.
module arsp_checker
    import arsp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input arsp_in_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input arsp_out_t m_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed or dropped while stalled");

    // input backpressure only when a result is waiting
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with empty output");

    // a transaction into an empty block shows up next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> m_valid)
        else $error("accepted byte did not produce a result");

    // entry completion only on a status byte, and never on an empty payload flag
    a_entry_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.entry_done |-> m_item.byte_kind == KIND_STATUS)
        else $error("entry_done on a non-status byte");

endmodule

bind arrival_record_stream_parser arsp_checker u_arsp_checker (.*);

// ----- sim/testbench.sv -----
// Testbench for arrival_record_stream_parser: byte stimulus, parser prediction and result checks.
module testbench;
    import arsp_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    arsp_in_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    arsp_out_t m_item;

    arrival_record_stream_parser i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // parser state as the predictor sees it
    logic [3:0] phase      = KIND_COUNT;
    logic [3:0] target_cnt = '0;
    logic [3:0] done_cnt   = '0;
    logic [7:0] str_left   = '0;
    logic [7:0] str_pos    = '0;
    logic [7:0] min_hi     = '0;
    logic [7:0] min_lo     = '0;

    arsp_out_t  tagged_bytes[$];
    logic [7:0] payload_bytes[$];
    int failures     = 0;
    int useful_items = 0;
    int cycle_count  = 0;
    int hold_left    = 0;
    int stall_left   = 0;
    bit tx_gaps_on   = 1'b1;
    bit rx_stalls_on = 1'b1;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic int pick_len(input int longest);
        if ($urandom_range(0, 63) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, longest);
    endfunction

    // role tagging of one accepted byte; pushes the expected transaction
    task automatic tag_byte(input arsp_in_t it);
        arsp_out_t e;
        logic      fin;
        e = '0;
        e.data_value = it.data_byte;
        fin = it.last_byte;
        if (it.empty_payload) begin
            e.byte_kind  = KIND_EMPTY;
            e.data_value = '0;
            fin = 1'b1;
        end else begin
            e.byte_kind = phase;
            if (phase != KIND_COUNT && phase != KIND_IGNORED)
                e.entry_index = done_cnt[2:0];
            case (phase) inside
                KIND_COUNT: begin
                    target_cnt = (it.data_byte > MAX_ENTRIES_B) ? 4'(MAX_ENTRIES)
                                                                : it.data_byte[3:0];
                    done_cnt = '0;
                    phase = (target_cnt == 0) ? KIND_IGNORED : KIND_RED;
                end
                KIND_RED:   phase = KIND_GREEN;
                KIND_GREEN: phase = KIND_BLUE;
                KIND_BLUE:  phase = KIND_ROUTE_LEN;
                KIND_ROUTE_LEN, KIND_HEAD_LEN: begin
                    str_left = it.data_byte;
                    str_pos  = '0;
                    if (it.data_byte == 0)
                        phase = (phase == KIND_ROUTE_LEN) ? KIND_HEAD_LEN : KIND_MIN_HI;
                    else
                        phase = (phase == KIND_ROUTE_LEN) ? KIND_ROUTE_CHR : KIND_HEAD_CHR;
                end
                KIND_ROUTE_CHR, KIND_HEAD_CHR: begin
                    e.char_pos = str_pos;
                    e.kept = str_pos < ((phase == KIND_ROUTE_CHR) ? ROUTE_KEEP : HEAD_KEEP);
                    str_pos++;
                    str_left--;
                    if (str_left == 0)
                        phase = (phase == KIND_ROUTE_CHR) ? KIND_HEAD_LEN : KIND_MIN_HI;
                end
                KIND_MIN_HI: begin
                    min_hi = it.data_byte;
                    phase  = KIND_MIN_LO;
                end
                KIND_MIN_LO: begin
                    min_lo = it.data_byte;
                    phase  = KIND_STATUS;
                end
                KIND_STATUS: begin
                    e.entry_done  = 1'b1;
                    e.minutes     = {min_hi, min_lo};
                    e.status_code = it.data_byte;
                    done_cnt++;
                    phase = (done_cnt >= target_cnt) ? KIND_IGNORED : KIND_RED;
                end
                default: begin
                    e.byte_kind = KIND_IGNORED;
                    phase = KIND_IGNORED;
                end
            endcase
        end
        e.entries_parsed = done_cnt;
        e.payload_done   = fin;
        if (fin) begin
            e.truncated = done_cnt < target_cnt;
            phase      = KIND_COUNT;
            target_cnt = '0;
            done_cnt   = '0;
            str_left   = '0;
            str_pos    = '0;
            min_hi     = '0;
            min_lo     = '0;
        end
        if (e.byte_kind != KIND_IGNORED)
            useful_items++;
        tagged_bytes.push_back(e);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        arsp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tagged_bytes.size() == 0) begin
                $error("result transaction with nothing expected, kind %0d", m_item.byte_kind);
                failures++;
            end else begin
                want = tagged_bytes.pop_front();
                check_field("byte_kind",      want.byte_kind,      m_item.byte_kind);
                check_field("data_value",     want.data_value,     m_item.data_value);
                check_field("entry_index",    want.entry_index,    m_item.entry_index);
                check_field("char_pos",       want.char_pos,       m_item.char_pos);
                check_field("kept",           want.kept,           m_item.kept);
                check_field("entry_done",     want.entry_done,     m_item.entry_done);
                check_field("minutes",        want.minutes,        m_item.minutes);
                check_field("status_code",    want.status_code,    m_item.status_code);
                check_field("payload_done",   want.payload_done,   m_item.payload_done);
                check_field("entries_parsed", want.entries_parsed, m_item.entries_parsed);
                check_field("truncated",      want.truncated,      m_item.truncated);
            end
        end
    end

    // result side: random stalls, plus a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // valid stays up after acceptance so a back-to-back byte needs no low-high toggle
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic emp);
        arsp_in_t it;
        int       gap;
        it.data_byte     = b;
        it.last_byte     = fin;
        it.empty_payload = emp;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        tag_byte(it);
    endtask

    task automatic idle_input();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_payload(input bit end_empty);
        for (int i = 0; i < payload_bytes.size(); i++)
            send_byte(payload_bytes[i], !end_empty && i == payload_bytes.size() - 1, 1'b0);
        if (end_empty)
            send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic add_entry(input int route_len, input int head_len);
        repeat (3) payload_bytes.push_back(8'($urandom));
        payload_bytes.push_back(8'(route_len));
        repeat (route_len) payload_bytes.push_back(8'($urandom));
        payload_bytes.push_back(8'(head_len));
        repeat (head_len) payload_bytes.push_back(8'($urandom));
        repeat (3) payload_bytes.push_back(8'($urandom));
    endtask

    task automatic build_random_payload();
        int r;
        int cnt;
        payload_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 8)
            cnt = 0;
        else if (r < 16)
            cnt = $urandom_range(MAX_ENTRIES + 1, 255);
        else
            cnt = $urandom_range(1, MAX_ENTRIES);
        payload_bytes.push_back(8'(cnt));
        repeat ((cnt > MAX_ENTRIES) ? MAX_ENTRIES : cnt)
            add_entry(pick_len(ROUTE_CAP + 2), pick_len(HEADSIGN_CAP + 3));
    endtask

    task automatic test_empty_payload();
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'hA5, 1'b0, 1'b1);
        idle_input();
    endtask

    // zero count: everything after the count byte is ignored, no truncation
    task automatic test_zero_count();
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b1, 1'b0);
        idle_input();
    endtask

    // count above the maximum, then cut short by an empty flag mid entry
    task automatic test_clamped_count();
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h02, 1'b0, 1'b0);
        send_byte(8'h03, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        idle_input();
    endtask

    // route of ROUTE_CAP chars (one more than are kept), empty headsign, minutes and status extremes
    task automatic test_string_capacity();
        payload_bytes = '{8'h01, 8'h00, 8'hFF, 8'h5A, 8'(ROUTE_CAP)};
        repeat (ROUTE_CAP) payload_bytes.push_back(8'($urandom));
        payload_bytes.push_back(8'h00);
        payload_bytes.push_back(8'hFF);
        payload_bytes.push_back(8'h00);
        payload_bytes.push_back(8'h7F);
        send_payload(1'b0);
        idle_input();
    endtask

    task automatic test_backpressure();
        bit gaps_saved;
        gaps_saved = tx_gaps_on;
        tx_gaps_on = 1'b0;
        hold_left  = HOLD_CYCLES;
        payload_bytes = '{8'h02};
        add_entry(3, 6);
        add_entry(0, 9);
        send_payload(1'b0);
        tx_gaps_on = gaps_saved;
        idle_input();
    endtask

    // char positions past 127 in both strings
    task automatic test_long_strings();
        payload_bytes = '{8'h01};
        add_entry(140, 133);
        send_payload(1'b0);
        idle_input();
    endtask

    task automatic test_random_payloads();
        int  r;
        int  keep;
        int  burst;
        bit  end_empty;
        while (useful_items < RANDOM_ITEMS) begin
            tx_gaps_on   = ($urandom_range(0, 4) != 0);
            rx_stalls_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 12);
                for (int i = 0; i < burst; i++)
                    send_byte(8'($urandom), (i == burst - 1) || ($urandom_range(0, 7) == 0),
                              1'($urandom_range(0, 15) == 0));
            end else begin
                build_random_payload();
                end_empty = 1'b0;
                r = $urandom_range(0, 99);
                if (r >= 93) begin
                    end_empty = 1'b1;
                end else if (r >= 80) begin
                    repeat ($urandom_range(1, 6)) payload_bytes.push_back(8'($urandom));
                end
                if ((r >= 65 && r < 80) || end_empty) begin
                    if (payload_bytes.size() > 1) begin
                        keep = $urandom_range(1, payload_bytes.size() - 1);
                        while (payload_bytes.size() > keep) void'(payload_bytes.pop_back());
                    end
                end
                send_payload(end_empty);
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        idle_input();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_payload();
        test_zero_count();
        test_clamped_count();
        test_string_capacity();
        test_backpressure();
        test_long_strings();
        test_random_payloads();
        while (tagged_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- arrival_record_stream_parser.f -----
rtl/arsp_pkg.sv
rtl/arrival_record_stream_parser.sv
rtl/arsp_checker.sv
sim/testbench.sv
